@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("frame ring assertion failed");

// Clocked assertion, checked in and out of reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("frame ring assertion failed");

`endif

@@ design/frlb_pkg.sv @@
// Shared constants, codes and control types of the frame ring block.
package frlb_pkg;

  localparam int RING_DEPTH_DEF = 8;

  localparam int TS_W   = 64;
  localparam int DIM_W  = 12;
  localparam int IVL_W  = 9;
  localparam int PROD_W = 2 * DIM_W;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam int DIV_N_W     = 32;
  localparam int DIV_D_W     = DIM_W;
  localparam int DIV_BITS    = 2;
  localparam int DIV_STEPS   = DIV_N_W / DIV_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam int PACE_DIVISOR = 1000;
  localparam int PACE_OFF     = 10;
  localparam int PACE_MIN     = 5;
  localparam int PACE_MAX     = 500;
  localparam int PACE_RESET   = 40;
  localparam int BORDER       = 2;

  // microsecond window whose quotient lands in the pacing range
  localparam int PACE_LO_US   = (PACE_MIN + PACE_OFF) * PACE_DIVISOR;
  localparam int PACE_HI_US   = (PACE_MAX + PACE_OFF + 1) * PACE_DIVISOR - 1;

  // reciprocal of the divisor, exact for dividends below 2**PACE_LOW_W
  localparam int PACE_LOW_W   = 19;
  localparam int PACE_RECIP_W = 20;
  localparam int PACE_SHIFT   = 29;
  localparam int PACE_RECIP   = 536871;
  localparam int PACE_QUO_W   = 10;

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_SURF_W = 1'b0;
  localparam logic REG_SURF_H = 1'b1;

  typedef struct packed {
    logic take;
    logic mul;
    logic rect_load;
    logic div_step;
    logic deliver;
  } frlb_cmd_t;

  typedef struct packed {
    logic in_mode;
    logic tick_hit;
    logic dims_zero;
    logic div_last;
    logic out_free;
  } frlb_sts_t;

endpackage

@@ design/frlb_if.sv @@
// Input and result channel interfaces of the frame ring block.
interface frlb_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [frlb_pkg::TS_W-1:0]      frame_timestamp;
  logic [frlb_pkg::DIM_W-1:0]     frame_width;
  logic [frlb_pkg::DIM_W-1:0]     frame_height;
  logic                           store_ok;

  modport source(output valid, mode, frame_timestamp, frame_width, frame_height, store_ok,
                 input ready);
  modport sink(input valid, mode, frame_timestamp, frame_width, frame_height, store_ok,
               output ready);
endinterface

interface frlb_out_if;
  logic                              valid;
  logic                              ready;
  logic                              item_valid;
  logic                              dropped_oldest;
  logic [frlb_pkg::TS_W-1:0]         shown_timestamp;
  logic                              rect_valid;
  logic signed [frlb_pkg::DIM_W-1:0] rect_x;
  logic signed [frlb_pkg::DIM_W-1:0] rect_y;
  logic [frlb_pkg::DIM_W-1:0]        rect_w;
  logic [frlb_pkg::DIM_W-1:0]        rect_h;
  logic [frlb_pkg::IVL_W-1:0]        interval_ms;

  modport source(output valid, item_valid, dropped_oldest, shown_timestamp, rect_valid,
                 rect_x, rect_y, rect_w, rect_h, interval_ms,
                 input ready);
  modport sink(input valid, item_valid, dropped_oldest, shown_timestamp, rect_valid,
               rect_x, rect_y, rect_w, rect_h, interval_ms,
               output ready);
endinterface

@@ design/frlb_ctrl.sv @@
// Sequencer of the frame ring block: steps one item through the datapath.
module frlb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  frlb_pkg::frlb_sts_t sts,
  output frlb_pkg::frlb_cmd_t cmd
);
  import frlb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SEL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.in_mode == MODE_STORE) begin
            state_next = S_DONE;
          end else begin
            state_next = sts.tick_hit ? S_MUL : S_DONE;
          end
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = sts.dims_zero ? S_DONE : S_SEL;
      end
      S_SEL: begin
        cmd.rect_load = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.deliver = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/frlb_dp.sv @@
// Datapath of the frame ring block: ring store, pointers, divider, result register.
module frlb_dp #(
  parameter int RING_DEPTH = frlb_pkg::RING_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [frlb_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [frlb_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [frlb_pkg::APB_DATA_W-1:0]   prdata,
  input  logic                              in_mode,
  input  logic [frlb_pkg::TS_W-1:0]         in_timestamp,
  input  logic [frlb_pkg::DIM_W-1:0]        in_width,
  input  logic [frlb_pkg::DIM_W-1:0]        in_height,
  input  logic                              in_store_ok,
  input  frlb_pkg::frlb_cmd_t               cmd,
  output frlb_pkg::frlb_sts_t               sts,
  frlb_out_if.source                        results
);
  import frlb_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam int ENT_W = TS_W + 2 * DIM_W;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  logic                  cfg_wr;
  logic [DIM_W-1:0]      surf_w, surf_h;

  logic [ENT_W-1:0]      ring_mem [RING_DEPTH];
  logic [ENT_W-1:0]      rd_q;
  logic [TS_W-1:0]       ent_ts;
  logic [DIM_W-1:0]      ent_w, ent_h;
  logic [RING_DEPTH-1:0] filled;
  logic [PTR_W-1:0]      wr_ptr, rd_ptr;
  logic                  overrun;

  logic [TS_W-1:0]       last_stamp, stamp_diff;
  logic [IVL_W-1:0]      pace_ivl, pace_cand, ivl_now;
  logic                  pace_go, pace_hit;
  logic [PACE_LOW_W+PACE_RECIP_W-1:0] pace_prod;
  logic [PACE_QUO_W-1:0] pace_quo;

  logic                  it_mode, it_valid, it_dropped, it_pace, it_rect, it_wide;
  logic [PROD_W-1:0]     prod_a, prod_b;
  logic                  rect_wide;

  logic [DIV_N_W-1:0]    div_num, num_step;
  logic [DIV_D_W-1:0]    div_rem, rem_step, div_den;
  logic [DIV_CNT_W-1:0]  div_cnt;

  logic [DIM_W-1:0]      rect_cw, rect_ch, rect_x, rect_y;
  logic                  out_valid;

  // configuration registers
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      surf_w <= '0;
      surf_h <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[APB_ADDR_W-1])
        REG_SURF_W: surf_w <= pwdata[DIM_W-1:0];
        REG_SURF_H: surf_h <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[APB_ADDR_W-1])
      REG_SURF_W: prdata = APB_DATA_W'(surf_w);
      REG_SURF_H: prdata = APB_DATA_W'(surf_h);
      default:    prdata = '0;
    endcase
  end

  // ring store
  assign ent_ts  = rd_q[ENT_W-1 -: TS_W];
  assign ent_w   = rd_q[2*DIM_W-1 -: DIM_W];
  assign ent_h   = rd_q[DIM_W-1:0];
  assign overrun = (rd_ptr == wr_ptr) && filled[ring_next(rd_ptr)];

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (in_mode == MODE_STORE) begin
        ring_mem[wr_ptr] <= {in_timestamp, in_width, in_height};
      end else begin
        rd_q <= ring_mem[rd_ptr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled     <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      last_stamp <= '0;
    end else if (cmd.take) begin
      if (in_mode == MODE_STORE) begin
        last_stamp <= in_timestamp;
        if (overrun) begin
          rd_ptr <= ring_next(rd_ptr);
        end
        filled[wr_ptr] <= in_store_ok;
        if (in_store_ok) begin
          wr_ptr <= ring_next(wr_ptr);
        end
      end else if (filled[rd_ptr]) begin
        filled[rd_ptr] <= 1'b0;
        rd_ptr         <= ring_next(rd_ptr);
      end
    end
  end

  // per-item state
  assign stamp_diff = in_timestamp - last_stamp;
  assign pace_go    = (last_stamp != '0) && !stamp_diff[DIV_N_W-1];
  assign rect_wide  = prod_a > prod_b;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      it_mode    <= in_mode;
      it_dropped <= (in_mode == MODE_STORE) && overrun;
      it_valid   <= (in_mode == MODE_STORE) ? in_store_ok : filled[rd_ptr];
      it_pace    <= (in_mode == MODE_STORE) && pace_go;
      it_rect    <= 1'b0;
    end
    if (cmd.mul) begin
      it_rect <= !sts.dims_zero;
      prod_a  <= ent_w * surf_h;
      prod_b  <= ent_h * surf_w;
    end
    if (cmd.rect_load) begin
      it_wide <= rect_wide;
    end
  end

  // radix-4 restoring divider for the rectangle
  always_comb begin
    logic [DIV_D_W:0] trial;
    num_step = div_num;
    rem_step = div_rem;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial    = {rem_step, num_step[DIV_N_W-1]};
      num_step = {num_step[DIV_N_W-2:0], 1'b0};
      if (trial >= {1'b0, div_den}) begin
        rem_step    = DIV_D_W'(trial - {1'b0, div_den});
        num_step[0] = 1'b1;
      end else begin
        rem_step = trial[DIV_D_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      div_num <= stamp_diff[DIV_N_W-1:0];
    end else if (cmd.rect_load) begin
      div_num <= DIV_N_W'(rect_wide ? prod_b : prod_a);
      div_den <= rect_wide ? ent_w : ent_h;
      div_rem <= '0;
      div_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (cmd.div_step) begin
      div_num <= num_step;
      div_rem <= rem_step;
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // pacing: div_num holds the low stamp difference for a store
  assign pace_prod = div_num[PACE_LOW_W-1:0] * PACE_RECIP_W'(PACE_RECIP);
  assign pace_quo  = pace_prod[PACE_SHIFT +: PACE_QUO_W];
  assign pace_hit  = (it_mode == MODE_STORE) && it_pace
                     && (div_num >= DIV_N_W'(PACE_LO_US))
                     && (div_num <= DIV_N_W'(PACE_HI_US));
  assign pace_cand = IVL_W'(pace_quo - PACE_QUO_W'(PACE_OFF));
  assign ivl_now   = pace_hit ? pace_cand : pace_ivl;

  always_ff @(posedge clk) begin
    if (rst) begin
      pace_ivl <= IVL_W'(PACE_RESET);
    end else if (cmd.deliver && pace_hit) begin
      pace_ivl <= pace_cand;
    end
  end

  // letterbox placement
  assign rect_cw = it_wide ? surf_w : div_num[DIM_W-1:0];
  assign rect_ch = it_wide ? div_num[DIM_W-1:0] : surf_h;
  assign rect_x  = ((surf_w - rect_cw) >> 1) - DIM_W'(BORDER);
  assign rect_y  = ((surf_h - rect_ch) >> 1) - DIM_W'(BORDER);

  // status
  assign sts.in_mode   = in_mode;
  assign sts.tick_hit  = filled[rd_ptr];
  assign sts.dims_zero = (ent_w == '0) || (ent_h == '0) || (surf_w == '0) || (surf_h == '0);
  assign sts.div_last  = (div_cnt == '0);
  assign sts.out_free  = !out_valid || results.ready;

  // result register
  assign results.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      results.item_valid      <= it_valid;
      results.dropped_oldest  <= it_dropped;
      results.shown_timestamp <= ((it_mode == MODE_TICK) && it_valid) ? ent_ts : '0;
      results.rect_valid      <= it_rect;
      results.rect_x          <= it_rect ? $signed(rect_x) : '0;
      results.rect_y          <= it_rect ? $signed(rect_y) : '0;
      results.rect_w          <= it_rect ? rect_cw : '0;
      results.rect_h          <= it_rect ? rect_ch : '0;
      results.interval_ms     <= ivl_now;
    end
  end

endmodule

@@ design/frame_ring_with_pacing_and_letterbox.sv @@
// Top level of the frame descriptor ring with pacing and letterbox placement.
//
//   port     kind        dir  contents
//   frames   valid/ready in   mode, frame_timestamp, frame_width, frame_height, store_ok
//   results  valid/ready out  item_valid .. interval_ms, one item per input item
//   apb      psel/penable in  surface_width at 0x0, surface_height at 0x4
//
// Store and empty tick: take, then done; tick with a zero size: take, multiply, done;
// tick that pops a frame: take, multiply, select, 2-bit-per-cycle divider (16 steps), done.
// One item is in work at a time; the next is taken while a result waits.
// A stalled result holds its register and the item after it waits in the last state.
// Synchronous reset clears the ring flags, pointers, last stamp and sets the interval to 40.
module frame_ring_with_pacing_and_letterbox #(
  parameter int RING_DEPTH = frlb_pkg::RING_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  frlb_in_if.sink                         frames,
  frlb_out_if.source                      results,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [frlb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [frlb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [frlb_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import frlb_pkg::*;

  frlb_cmd_t cmd;
  frlb_sts_t sts;
  logic      in_ready;

  assign frames.ready = in_ready;
  assign pready       = 1'b1;

  frlb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (frames.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  frlb_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .in_mode      (frames.mode),
    .in_timestamp (frames.frame_timestamp),
    .in_width     (frames.frame_width),
    .in_height    (frames.frame_height),
    .in_store_ok  (frames.store_ok),
    .cmd          (cmd),
    .sts          (sts),
    .results      (results)
  );

endmodule

@@ design/frlb_checker.sv @@
// Port-level assertions of the frame ring block and their binding.
`include "assert_macros.svh"

module frlb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         item_valid,
  input logic                         dropped_oldest,
  input logic                         rect_valid,
  input logic [frlb_pkg::IVL_W-1:0]   interval_ms
);
  import frlb_pkg::*;

  // a pending result is not withdrawn
  `ASSERT_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)

  // one item in work: input closes right after a take
  `ASSERT_RST(a_one_item, clk, rst, in_valid && in_ready |=> !in_ready)

  `ASSERT_RST(a_ivl_range, clk, rst, out_valid |-> (interval_ms >= IVL_W'(PACE_MIN) && interval_ms <= IVL_W'(PACE_MAX)))

  // a rectangle only comes with a popped frame on a tick
  `ASSERT_RST(a_rect_src, clk, rst, out_valid && rect_valid |-> item_valid && !dropped_oldest)

  `ASSERT_ALWAYS(a_rst_clear, clk, $past(rst) |-> !out_valid)

endmodule

bind frame_ring_with_pacing_and_letterbox frlb_checker u_frlb_chk (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (frames.valid),
  .in_ready       (frames.ready),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .item_valid     (results.item_valid),
  .dropped_oldest (results.dropped_oldest),
  .rect_valid     (results.rect_valid),
  .interval_ms    (results.interval_ms)
);
